// ===== hdl/chac_pkg.sv =====
`default_nettype none

package chac_pkg;

  // debounce counters saturate at a confirmation count of at most 15
  localparam int unsigned CNT_W = 4;
  localparam int unsigned NRULES = 5;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [7:0] SERVO_OPEN_DEG = 8'd180;
  localparam logic [7:0] SERVO_SHUT_DEG = 8'd0;

  // rule slots
  localparam int unsigned R_TEMP = 0;
  localparam int unsigned R_CO2  = 1;
  localparam int unsigned R_HUM  = 2;
  localparam int unsigned R_SOIL = 3;
  localparam int unsigned R_VENT = 4;

  typedef enum logic [2:0] {
    CFG_AUTO_ENABLED   = 3'd0,
    CFG_TEMP_HIGH      = 3'd1,
    CFG_CO2_HIGH       = 3'd2,
    CFG_HUM_HIGH       = 3'd3,
    CFG_SOIL_WET_LEVEL = 3'd4,
    CFG_SOIL_DRY_LEVEL = 3'd5,
    CFG_SOIL_RAW_MODE  = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_FAN_FWD   = 3'd1,
    CMD_FAN_REV   = 3'd2,
    CMD_FAN_STOP  = 3'd3,
    CMD_PUMP_ON   = 3'd4,
    CMD_PUMP_OFF  = 3'd5,
    CMD_SERVO_180 = 3'd6,
    CMD_SERVO_0   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    FAN_STOP = 2'd0,
    FAN_FWD  = 2'd1,
    FAN_REV  = 2'd2
  } fan_e;

  typedef struct packed {
    logic               auto_enabled;
    logic signed [11:0] temp_high;
    logic [15:0]        co2_high;
    logic [9:0]         hum_high;
    logic [9:0]         soil_wet_level;
    logic [9:0]         soil_dry_level;
    logic               soil_raw_mode;
  } cfg_t;

  // one classified sample: mismatch mask (bit0 fan, bit1 pump, bit2 servo) and wanted state
  typedef struct packed {
    logic [2:0] mask;
    fan_e       fan_dir;
    logic       pump_on;
    logic       vent_open;
    logic [3:0] rules_active;
  } desc_t;

endpackage

`default_nettype wire

// ===== hdl/chac_if.sv =====
`default_nettype none

interface chac_in_if;
  logic               valid;
  logic               ready;
  logic               temp_valid;
  logic signed [11:0] temperature;
  logic               co2_valid;
  logic [15:0]        co2_ppm;
  logic               hum_valid;
  logic [9:0]         humidity;
  logic signed [10:0] soil_level;
  logic               has_data;
  logic               node_online;
  logic [1:0]         fan_reported;
  logic               pump_reported;
  logic [7:0]         servo_reported;

  modport source (
    output valid, temp_valid, temperature, co2_valid, co2_ppm, hum_valid, humidity,
           soil_level, has_data, node_online, fan_reported, pump_reported, servo_reported,
    input  ready
  );
  modport sink (
    input  valid, temp_valid, temperature, co2_valid, co2_ppm, hum_valid, humidity,
           soil_level, has_data, node_online, fan_reported, pump_reported, servo_reported,
    output ready
  );
endinterface

interface chac_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic       last;
  logic [1:0] fan_direction;
  logic       pump_on;
  logic       vent_open;
  logic [3:0] rules_active;

  modport source (
    output valid, command, last, fan_direction, pump_on, vent_open, rules_active,
    input  ready
  );
  modport sink (
    input  valid, command, last, fan_direction, pump_on, vent_open, rules_active,
    output ready
  );
endinterface

interface chac_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/climate_hysteresis_actuator_ctrl.sv =====
// Climate rule controller: each sample transaction updates five debounced hysteresis
// rules (temperature, CO2, humidity, soil, vent) in the cycle it is accepted, when
// automation is enabled and it has data, and queues the wanted fan, pump and vent state
// with the mismatches against the reported actuators. An input transaction is accepted
// every cycle while the 4-entry queue has room. The output stage emits one result per
// cycle while the sink is ready: 1 to 3 results per sample (one per mismatched actuator
// while online, else a single 'none'), last marks the final one. A sample passes through
// the queue and the output register before its first result is offered.
// Configuration writes are always ready and take effect the next cycle.
`default_nettype none

module climate_hysteresis_actuator_ctrl #(
  parameter int unsigned CONFIRM_N = 3,
  parameter int unsigned TEMP_HYST = 10,
  parameter int unsigned CO2_HYST  = 100,
  parameter int unsigned HUM_HYST  = 50,
  parameter int unsigned OVER_PCT  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chac_cfg_if.sink    cfg_i,
  chac_in_if.sink     in_i,
  chac_out_if.source  out_o
);
  import chac_pkg::*;

  cfg_t  cfg_q;
  desc_t push_desc, head;
  logic  push, pop, full, empty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_enabled   <= 1'b1;
      cfg_q.temp_high      <= 12'sd300;
      cfg_q.co2_high       <= 16'd1000;
      cfg_q.hum_high       <= 10'd800;
      cfg_q.soil_wet_level <= 10'd400;
      cfg_q.soil_dry_level <= 10'd700;
      cfg_q.soil_raw_mode  <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_AUTO_ENABLED:   cfg_q.auto_enabled   <= cfg_i.data[0];
        CFG_TEMP_HIGH:      cfg_q.temp_high      <= cfg_i.data[11:0];
        CFG_CO2_HIGH:       cfg_q.co2_high       <= cfg_i.data[15:0];
        CFG_HUM_HIGH:       cfg_q.hum_high       <= cfg_i.data[9:0];
        CFG_SOIL_WET_LEVEL: cfg_q.soil_wet_level <= cfg_i.data[9:0];
        CFG_SOIL_DRY_LEVEL: cfg_q.soil_dry_level <= cfg_i.data[9:0];
        CFG_SOIL_RAW_MODE:  cfg_q.soil_raw_mode  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  chac_front #(
    .CONFIRM_N(CONFIRM_N),
    .TEMP_HYST(TEMP_HYST),
    .CO2_HYST (CO2_HYST),
    .HUM_HYST (HUM_HYST),
    .OVER_PCT (OVER_PCT)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .desc_o(push_desc)
  );

  chac_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head)
  );

  chac_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== hdl/chac_front.sv =====
`default_nettype none

module chac_front #(
  parameter int unsigned CONFIRM_N = 3,
  parameter int unsigned TEMP_HYST = 10,
  parameter int unsigned CO2_HYST  = 100,
  parameter int unsigned HUM_HYST  = 50,
  parameter int unsigned OVER_PCT  = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  chac_pkg::cfg_t cfg_i,
  chac_in_if.sink       in_i,
  input  logic          full_i,
  output logic          push_o,
  output chac_pkg::desc_t desc_o
);
  import chac_pkg::*;

  // compare width covers 16-bit readings minus the largest hysteresis
  localparam int unsigned CW = 18;
  // product width covers a 16-bit reading times (100 + OVER_PCT)
  localparam int unsigned VW = 26;
  localparam logic [CNT_W-1:0] ConfirmCnt = CNT_W'(CONFIRM_N);
  localparam logic signed [CW-1:0] TempHystS = CW'(TEMP_HYST);
  localparam logic signed [CW-1:0] Co2HystS  = CW'(CO2_HYST);
  localparam logic signed [CW-1:0] HumHystS  = CW'(HUM_HYST);
  localparam logic signed [VW-1:0] Pct100    = VW'(100);
  localparam logic signed [VW-1:0] PctOver   = VW'(100 + OVER_PCT);

  logic [CNT_W-1:0] over_cnt_q [NRULES];
  logic [CNT_W-1:0] over_cnt_d [NRULES];
  logic [CNT_W-1:0] safe_cnt_q [NRULES];
  logic [CNT_W-1:0] safe_cnt_d [NRULES];
  logic [NRULES-1:0] flag_q, flag_d;
  logic [NRULES-1:0] over, safe;

  logic accept, upd, emit;
  logic signed [CW-1:0] t_s, c_s, h_s, th_s, ch_s, hh_s;
  logic signed [CW-1:0] dry_s, wet_s;
  logic signed [10:0] soil_s;
  logic signed [VW-1:0] t_x, c_x, h_x, th_x, ch_x, hh_x;
  logic vo_t, vo_c, vo_h;
  fan_e fan;

  assign accept = in_i.valid && !full_i;
  assign in_i.ready = !full_i;
  assign upd = cfg_i.auto_enabled && in_i.has_data;
  assign emit = upd && in_i.node_online;

  assign t_s  = CW'(in_i.temperature);
  assign c_s  = CW'(signed'({1'b0, in_i.co2_ppm}));
  assign h_s  = CW'(signed'({1'b0, in_i.humidity}));
  assign th_s = CW'(cfg_i.temp_high);
  assign ch_s = CW'(signed'({1'b0, cfg_i.co2_high}));
  assign hh_s = CW'(signed'({1'b0, cfg_i.hum_high}));
  assign dry_s = CW'(signed'({1'b0, cfg_i.soil_dry_level}));
  assign wet_s = CW'(signed'({1'b0, cfg_i.soil_wet_level}));
  assign soil_s = in_i.soil_level;

  // vent threshold scaled by (100 + OVER_PCT) percent, compared exactly
  assign t_x  = VW'(t_s) * Pct100;
  assign c_x  = VW'(c_s) * Pct100;
  assign h_x  = VW'(h_s) * Pct100;
  assign th_x = VW'(th_s) * PctOver;
  assign ch_x = VW'(ch_s) * PctOver;
  assign hh_x = VW'(hh_s) * PctOver;

  assign vo_t = in_i.temp_valid && (t_s >= th_s) && (t_x >= th_x);
  assign vo_c = in_i.co2_valid && (c_s >= ch_s) && (c_x >= ch_x);
  assign vo_h = in_i.hum_valid && (h_s >= hh_s) && (h_x >= hh_x);

  always_comb begin
    over[R_TEMP] = in_i.temp_valid && (t_s >= th_s);
    safe[R_TEMP] = in_i.temp_valid && (t_s <= th_s - TempHystS);
    over[R_CO2]  = in_i.co2_valid && (c_s >= ch_s);
    safe[R_CO2]  = in_i.co2_valid && (c_s <= ch_s - Co2HystS);
    over[R_HUM]  = in_i.hum_valid && (h_s >= hh_s);
    safe[R_HUM]  = in_i.hum_valid && (h_s <= hh_s - HumHystS);
    if (cfg_i.soil_raw_mode) begin
      over[R_SOIL] = !soil_s[10] && (CW'(soil_s) >= dry_s);
      safe[R_SOIL] = !soil_s[10] && (CW'(soil_s) <= wet_s);
    end else begin
      // two-state sensor: zero reads dry, one reads wet
      over[R_SOIL] = (soil_s == 11'sd0);
      safe[R_SOIL] = (soil_s == 11'sd1);
    end
    over[R_VENT] = vo_t || vo_c || vo_h;
    safe[R_VENT] = (!in_i.temp_valid || t_s <= th_s) && (!in_i.co2_valid || c_s <= ch_s) &&
                   (!in_i.hum_valid || h_s <= hh_s);
  end

  always_comb begin
    for (int k = 0; k < NRULES; k++) begin
      over_cnt_d[k] = over_cnt_q[k];
      safe_cnt_d[k] = safe_cnt_q[k];
      flag_d[k]     = flag_q[k];
      if (upd && (over[k] || safe[k])) begin
        if (over[k]) begin
          if (over_cnt_q[k] < ConfirmCnt) begin
            over_cnt_d[k] = over_cnt_q[k] + CNT_W'(1);
          end
          safe_cnt_d[k] = '0;
        end else begin
          if (safe_cnt_q[k] < ConfirmCnt) begin
            safe_cnt_d[k] = safe_cnt_q[k] + CNT_W'(1);
          end
          over_cnt_d[k] = '0;
        end
        if (!flag_q[k] && over_cnt_d[k] >= ConfirmCnt) begin
          flag_d[k] = 1'b1;
        end else if (flag_q[k] && safe_cnt_d[k] >= ConfirmCnt) begin
          flag_d[k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NRULES; k++) begin
        over_cnt_q[k] <= '0;
        safe_cnt_q[k] <= '0;
      end
      flag_q <= '0;
    end else if (accept) begin
      for (int k = 0; k < NRULES; k++) begin
        over_cnt_q[k] <= over_cnt_d[k];
        safe_cnt_q[k] <= safe_cnt_d[k];
      end
      flag_q <= flag_d;
    end
  end

  // cooling wins over dehumidifying
  always_comb begin
    if (flag_d[R_TEMP] || flag_d[R_CO2]) begin
      fan = FAN_FWD;
    end else if (flag_d[R_HUM]) begin
      fan = FAN_REV;
    end else begin
      fan = FAN_STOP;
    end
  end

  always_comb begin
    desc_o.fan_dir      = fan;
    desc_o.pump_on      = flag_d[R_SOIL];
    desc_o.vent_open    = flag_d[R_VENT];
    desc_o.rules_active = flag_d[R_SOIL:R_TEMP];
    desc_o.mask[0] = emit && (in_i.fan_reported != fan);
    desc_o.mask[1] = emit && (in_i.pump_reported != flag_d[R_SOIL]);
    desc_o.mask[2] = emit &&
                     (in_i.servo_reported != (flag_d[R_VENT] ? SERVO_OPEN_DEG : SERVO_SHUT_DEG));
  end

  assign push_o = accept;

endmodule

`default_nettype wire

// ===== hdl/chac_fifo.sv =====
`default_nettype none

module chac_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  chac_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output chac_pkg::desc_t head_o
);
  import chac_pkg::*;

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);

  desc_t mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0] count_q, count_d;

  assign full_o  = (count_q == (PtrW+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/chac_back.sv =====
`default_nettype none

module chac_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  chac_pkg::desc_t head_i,
  output logic            pop_o,
  chac_out_if.source      out_o
);
  import chac_pkg::*;

  logic [2:0] done_q;
  logic [2:0] left, sel;
  logic       last, load;
  logic       valid_q;
  cmd_e       cmd;

  logic [2:0] cmd_q;
  logic       last_q;
  logic [1:0] fan_q;
  logic       pump_q, vent_q;
  logic [3:0] act_q;

  // commands still owed for the head entry, issued fan, pump, servo
  assign left = head_i.mask & ~done_q;
  assign sel  = left & (~left + 3'd1);
  assign last = ((left & (left - 3'd1)) == 3'b000);
  assign load = !empty_i && (!valid_q || out_o.ready);
  assign pop_o = load && last;

  always_comb begin
    priority if (sel[0]) begin
      unique case (head_i.fan_dir)
        FAN_FWD: cmd = CMD_FAN_FWD;
        FAN_REV: cmd = CMD_FAN_REV;
        default: cmd = CMD_FAN_STOP;
      endcase
    end else if (sel[1]) begin
      cmd = head_i.pump_on ? CMD_PUMP_ON : CMD_PUMP_OFF;
    end else if (sel[2]) begin
      cmd = head_i.vent_open ? CMD_SERVO_180 : CMD_SERVO_0;
    end else begin
      cmd = CMD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        done_q  <= last ? 3'b000 : (done_q | sel);
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= cmd;
      last_q <= last;
      fan_q  <= head_i.fan_dir;
      pump_q <= head_i.pump_on;
      vent_q <= head_i.vent_open;
      act_q  <= head_i.rules_active;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.command       = cmd_q;
  assign out_o.last          = last_q;
  assign out_o.fan_direction = fan_q;
  assign out_o.pump_on       = pump_q;
  assign out_o.vent_open     = vent_q;
  assign out_o.rules_active  = act_q;

endmodule

`default_nettype wire

// ===== hdl/chac_checker.sv =====
`default_nettype none

module chac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] command_i,
  input logic       last_i,
  input logic [1:0] fan_direction_i,
  input logic       pump_on_i,
  input logic [3:0] rules_active_i
);
  import chac_pkg::*;

  // a stalled result keeps its command and its end mark
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(command_i) && $stable(last_i))
    else $error("stalled result changed");

  // a status-only result always closes its sample
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && command_i == CMD_NONE |-> last_i)
    else $error("none result without last");

  // fan direction follows the rule flags, cooling first
  a_fan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((rules_active_i[0] || rules_active_i[1]) ? fan_direction_i == FAN_FWD :
                     (rules_active_i[2] ? fan_direction_i == FAN_REV :
                                          fan_direction_i == FAN_STOP)))
    else $error("fan direction inconsistent with rules");

  a_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pump_on_i == rules_active_i[3])
    else $error("pump state inconsistent with soil rule");

  // wanted state repeats on every result of one sample
  a_same_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i |-> $stable(rules_active_i))
    else $error("wanted state changed within a sample");

endmodule

bind climate_hysteresis_actuator_ctrl chac_checker u_chac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .command_i      (out_o.command),
  .last_i         (out_o.last),
  .fan_direction_i(out_o.fan_direction),
  .pump_on_i      (out_o.pump_on),
  .rules_active_i (out_o.rules_active)
);

`default_nettype wire
